// ===== rtl/ppct_pkg.sv =====
// Package for the polygon point/circle test engine: item codes, widths, queue entry type.
// Used by every module of the block; depends on nothing.
package ppct_pkg;
	localparam int DefMaxVertices = 64;
	localparam int DefCoordBits = 16;
	localparam int CoordW = 16;
	localparam int RadiusW = 15;
	localparam int AreaW = 38;
	localparam int SumW = 41;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_POINT  = 2'd2,
		FUNC_CIRCLE = 2'd3
	} func_t;

	typedef struct packed {
		func_t                    func;
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic [RadiusW-1:0]       r;
	} cmd_t;
endpackage

// ===== rtl/ppct_cmd_fifo.sv =====
// Two-entry item queue between the front end and the edge engine.
// Depends on ppct_pkg for the queue entry type.
module ppct_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  ppct_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output ppct_pkg::cmd_t rd_data,
	output logic           empty
);
	import ppct_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule

// ===== rtl/ppct_front.sv =====
// Front end: accepts items, masks coordinates to COORD_BITS and sign-extends them.
// Depends on ppct_pkg.
module ppct_front #(
	parameter int COORD_BITS = ppct_pkg::DefCoordBits
) (
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   func,
	input  logic signed [ppct_pkg::CoordW-1:0] coord_x,
	input  logic signed [ppct_pkg::CoordW-1:0] coord_y,
	input  logic [ppct_pkg::RadiusW-1:0] radius,
	input  logic                         q_full,
	output logic                         q_wr,
	output ppct_pkg::cmd_t               q_data
);
	import ppct_pkg::*;

	localparam int Cb = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;

	function automatic logic [CoordW-1:0] fix(input logic [CoordW-1:0] v);
		logic [CoordW-1:0] o;
		o = v;
		for (int k = Cb; k < CoordW; k++) o[k] = v[Cb-1];
		return o;
	endfunction

	assign full = q_full;
	assign q_wr = push && !q_full;
	always_comb begin
		q_data.func = func_t'(func);
		q_data.x = fix(coord_x);
		q_data.y = fix(coord_y);
		q_data.r = radius;
	end
endmodule

// ===== rtl/ppct_engine.sv =====
// Back end: vertex store, running bounds and area, and a per-edge sequencer for tests.
// Depends on ppct_pkg; reads items from the queue, writes one result register.
module ppct_engine #(
	parameter int MAX_VERTICES = ppct_pkg::DefMaxVertices
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  ppct_pkg::cmd_t q_data,
	output logic           q_rd,
	output logic           empty,
	input  logic           pop,
	output logic           inside_flag,
	output logic           circle_hit,
	output logic           empty_flag,
	output logic           overflow_flag,
	output logic signed [ppct_pkg::CoordW-1:0] min_x,
	output logic signed [ppct_pkg::CoordW-1:0] min_y,
	output logic signed [ppct_pkg::CoordW-1:0] max_x,
	output logic signed [ppct_pkg::CoordW-1:0] max_y,
	output logic [ppct_pkg::AreaW-1:0] area
);
	import ppct_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DW = CoordW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_RD1, S_RDW, S_EDGE, S_CALC1, S_CALC2, S_CALC3, S_CALC4,
		S_AREA1, S_AREA2, S_DONE
	} state_t;

	logic signed [CoordW-1:0] xm [MAX_VERTICES];
	logic signed [CoordW-1:0] ym [MAX_VERTICES];

	state_t state_q;
	cmd_t cmd_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q, raddr;
	logic signed [CoordW-1:0] rdx_q, rdy_q;
	logic signed [CoordW-1:0] x0_q, y0_q, xl_q, yl_q, xi_q, yi_q;
	logic signed [CoordW-1:0] mnx_q, mny_q, mxx_q, mxy_q;
	logic signed [SumW-1:0] psum_q;
	logic in_q, hit_q, ovf_q, rv_q;
	logic signed [DW-1:0] sx_q, sy_q, vx_q, vy_q;
	logic signed [2*DW+1:0] seg2_q, dot_q, vec2_q, cr_q, pa_q, pb_q;
	logic [2*DW+1:0] d_q;
	logic [2*RadiusW-1:0] r2_q;
	logic [4*DW+3:0] dd_q, rs_q;
	logic signed [SumW+1:0] tot_q;
	logic signed [2*DW+1:0] term_q;

	// last edge wraps to vertex zero
	logic last_edge;
	assign last_edge = ({1'b0, idx_q} + 1'b1) == (AW+1)'(cnt_q);
	assign empty = !rv_q;
	assign q_rd = (state_q == S_IDLE) && !q_empty && (!rv_q || pop);
	assign raddr = idx_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_rd && q_data.func == FUNC_APPEND
				&& cnt_q < CW'(MAX_VERTICES)) begin
			xm[cnt_q[AW-1:0]] <= q_data.x;
			ym[cnt_q[AW-1:0]] <= q_data.y;
		end
		rdx_q <= xm[raddr];
		rdy_q <= ym[raddr];
	end

	logic signed [SumW-1:0] pnew;
	assign pnew = SumW'((DW)'(xl_q) + DW'(cmd_q.x)) * SumW'(DW'(cmd_q.y) - DW'(yl_q));
	logic [SumW+1:0] tmag;
	assign tmag = tot_q[SumW+1] ? -tot_q : tot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			mnx_q <= '0; mny_q <= '0; mxx_q <= '0; mxy_q <= '0;
			psum_q <= '0;
			rv_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (pop && rv_q) rv_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_rd) begin
					cmd_q <= q_data;
					in_q <= 1'b0; hit_q <= 1'b0; ovf_q <= 1'b0;
					r2_q <= q_data.r * q_data.r;
					idx_q <= '0;
					case (q_data.func)
						FUNC_CLEAR: begin
							cnt_q <= '0; psum_q <= '0;
							mnx_q <= '0; mny_q <= '0; mxx_q <= '0; mxy_q <= '0;
							state_q <= S_AREA1;
						end
						FUNC_APPEND: begin
							if (cnt_q >= CW'(MAX_VERTICES)) begin
								ovf_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + 1'b1;
								if (cnt_q == '0) begin
									mnx_q <= q_data.x; mxx_q <= q_data.x;
									mny_q <= q_data.y; mxy_q <= q_data.y;
									x0_q <= q_data.x; y0_q <= q_data.y;
								end else begin
									if (q_data.x < mnx_q) mnx_q <= q_data.x;
									if (q_data.x > mxx_q) mxx_q <= q_data.x;
									if (q_data.y < mny_q) mny_q <= q_data.y;
									if (q_data.y > mxy_q) mxy_q <= q_data.y;
								end
							end
							state_q <= S_CALC1;
						end
						default: begin
							in_q <= (q_data.func == FUNC_POINT) && (cnt_q == '0);
							state_q <= (cnt_q == '0) ? S_AREA1 : S_RD0;
						end
					endcase
				end
				S_CALC1: begin
					// append: add edge term, remember new last vertex
					if (!ovf_q) begin
						if (cnt_q != CW'(1)) psum_q <= psum_q + pnew;
						xl_q <= cmd_q.x; yl_q <= cmd_q.y;
					end
					state_q <= S_AREA1;
				end
				S_RD0: begin
					state_q <= S_RD1;
				end
				S_RD1: begin
					xi_q <= rdx_q; yi_q <= rdy_q;
					idx_q <= last_edge ? '0 : idx_q + 1'b1;
					state_q <= S_RDW;
				end
				S_RDW: begin
					// store read of vertex j in flight
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					// rdx/rdy now hold vertex j
					sx_q <= DW'(rdx_q) - DW'(xi_q);
					sy_q <= DW'(rdy_q) - DW'(yi_q);
					vx_q <= DW'(cmd_q.x) - DW'(xi_q);
					vy_q <= DW'(cmd_q.y) - DW'(yi_q);
					if (cmd_q.func == FUNC_POINT) begin
						if ((yi_q <= cmd_q.y && rdy_q > cmd_q.y)
								|| (yi_q > cmd_q.y && rdy_q <= cmd_q.y))
							seg2_q <= (2*DW+2)'(1);
						else
							seg2_q <= '0;
					end
					xi_q <= rdx_q; yi_q <= rdy_q;
					state_q <= S_CALC2;
				end
				S_CALC2: begin
					if (cmd_q.func == FUNC_POINT) begin
						pa_q <= (2*DW+2)'(vy_q) * (2*DW+2)'(sx_q);
						pb_q <= (2*DW+2)'(vx_q) * (2*DW+2)'(sy_q);
						dot_q <= seg2_q;
					end else begin
						seg2_q <= (2*DW+2)'(sx_q) * (2*DW+2)'(sx_q)
							+ (2*DW+2)'(sy_q) * (2*DW+2)'(sy_q);
						dot_q <= (2*DW+2)'(sx_q) * (2*DW+2)'(vx_q)
							+ (2*DW+2)'(sy_q) * (2*DW+2)'(vy_q);
						vec2_q <= (2*DW+2)'(vx_q) * (2*DW+2)'(vx_q)
							+ (2*DW+2)'(vy_q) * (2*DW+2)'(vy_q);
						cr_q <= (2*DW+2)'(sx_q) * (2*DW+2)'(vy_q)
							- (2*DW+2)'(sy_q) * (2*DW+2)'(vx_q);
					end
					state_q <= S_CALC3;
				end
				S_CALC3: begin
					if (cmd_q.func == FUNC_POINT) begin
						if (dot_q[0] && ((sy_q > 0) ? (pa_q < pb_q) : (pa_q > pb_q)))
							in_q <= ~in_q;
					end else begin
						d_q <= cr_q[2*DW+1] ? -cr_q : cr_q;
						if ($unsigned(vec2_q) <= (2*DW+2)'(r2_q)) hit_q <= 1'b1;
					end
					state_q <= S_CALC4;
				end
				S_CALC4: begin
					if (cmd_q.func == FUNC_CIRCLE) begin
						dd_q <= (4*DW+4)'(d_q) * (4*DW+4)'(d_q);
						rs_q <= (4*DW+4)'(r2_q) * (4*DW+4)'($unsigned(seg2_q));
					end
					state_q <= (idx_q == '0 && cmd_q.func == FUNC_POINT) ? S_AREA1 : S_DONE;
				end
				S_DONE: begin
					// circle compare for this edge, then next edge or finish
					if (cmd_q.func == FUNC_CIRCLE && seg2_q > 0 && dot_q >= 0
							&& dot_q <= seg2_q && dd_q <= rs_q)
						hit_q <= 1'b1;
					state_q <= (idx_q == '0) ? S_AREA1 : S_RD1;
				end
				S_AREA1: begin
					term_q <= (2*DW+2)'(DW'(xl_q) + DW'(x0_q))
						* (2*DW+2)'(DW'(y0_q) - DW'(yl_q));
					state_q <= S_AREA2;
				end
				S_AREA2: begin
					tot_q <= (SumW+2)'(psum_q) + (SumW+2)'(term_q);
					state_q <= S_IDLE;
					rv_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign inside_flag = in_q;
	assign circle_hit = hit_q && (cmd_q.func == FUNC_CIRCLE);
	assign empty_flag = (cnt_q == '0);
	assign overflow_flag = ovf_q;
	assign min_x = mnx_q;
	assign min_y = mny_q;
	assign max_x = mxx_q;
	assign max_y = mxy_q;
	assign area = (cnt_q == '0) ? '0
		: (|tmag[SumW+1:AreaW+1]) ? {AreaW{1'b1}} : tmag[AreaW:1];
endmodule

// ===== rtl/polygon_point_circle_test_engine_unit.sv =====
// Polygon point/circle test engine. Every item ends with the area steps; point and circle
// tests over the stored vertices first walk every edge through the registered vertex
// store read and the one shared edge datapath. A new item is taken only when the back
// end is idle and any waiting result is gone or being popped; a waiting result holds
// the back end, a two-entry queue decouples accept.
// Asynchronous active-low reset empties the store, bounds and area; no clearing pass.
module polygon_point_circle_test_engine_unit #(
	parameter int MAX_VERTICES = ppct_pkg::DefMaxVertices,
	parameter int COORD_BITS = ppct_pkg::DefCoordBits
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [1:0] func,
	input  logic signed [ppct_pkg::CoordW-1:0] coord_x,
	input  logic signed [ppct_pkg::CoordW-1:0] coord_y,
	input  logic [ppct_pkg::RadiusW-1:0] radius,
	output logic empty,
	input  logic pop,
	output logic inside_flag,
	output logic circle_hit,
	output logic empty_flag,
	output logic overflow_flag,
	output logic signed [ppct_pkg::CoordW-1:0] min_x,
	output logic signed [ppct_pkg::CoordW-1:0] min_y,
	output logic signed [ppct_pkg::CoordW-1:0] max_x,
	output logic signed [ppct_pkg::CoordW-1:0] max_y,
	output logic [ppct_pkg::AreaW-1:0] area
);
	import ppct_pkg::*;

	cmd_t wd, rd;
	logic wr, qf, qe, qr;

	ppct_front #(.COORD_BITS(COORD_BITS)) u_front (
		.push, .full, .func, .coord_x, .coord_y, .radius,
		.q_full(qf), .q_wr(wr), .q_data(wd)
	);

	ppct_cmd_fifo u_fifo (
		.clk, .arst_n, .wr_en(wr), .wr_data(wd), .full(qf),
		.rd_en(qr), .rd_data(rd), .empty(qe)
	);

	ppct_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
		.clk, .arst_n, .q_empty(qe), .q_data(rd), .q_rd(qr), .empty, .pop,
		.inside_flag, .circle_hit, .empty_flag, .overflow_flag,
		.min_x, .min_y, .max_x, .max_y, .area
	);
endmodule
